@@ rtl/sha1_pkg.sv @@
// Shared types and constants for the single-block SHA-1 hash core.
package sha1_pkg;

   localparam logic [5:0] MaxBytes = 6'd55;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PadByte = 8'h80;

   // One finished message as handed from the front part to the back part.
   typedef struct packed {
      logic [511:0] block;     // padded block, word 0 in the top bits
      logic         too_long;
   } msg_type;

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      rotl1 = {x[30:0], x[31]};
   endfunction

endpackage

@@ rtl/sha1_front.sv @@
// Front part: collects message bytes and builds the padded block.
module sha1_front import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        msg_valid,
   input  logic        msg_stall,
   output msg_type     msg_data
);

   logic [31:0] words_ff [16];
   logic [31:0] words_in [16];
   logic [5:0]  count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic        full_ff, full_in;
   msg_type     q_ff, q_in;
   logic        accept;

   assign req_stall = full_ff;
   assign accept    = req_valid & ~full_ff;
   assign msg_valid = full_ff;
   assign msg_data  = q_ff;

   always_comb begin
      logic [5:0]   n;
      logic         ovf;
      logic [511:0] blk;
      words_in = words_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      full_in  = full_ff & msg_stall;
      q_in     = q_ff;
      n        = count_ff;
      ovf      = ovf_ff;
      blk      = '0;
      if (accept && req_has_byte) begin
         if (count_ff >= MaxBytes) begin
            ovf = 1'b1;
         end else begin
            words_in[count_ff[5:2]][8*(3-count_ff[1:0]) +: 8] = req_data_byte;
            n = count_ff + 6'd1;
         end
      end
      if (accept && req_end_of_message) begin
         for (int i = 0; i < 16; i++) begin
            blk[32*(15-i) +: 32] = words_in[i];
         end
         // pad byte follows the message, bit length in the last word
         blk[8*(63 - n) +: 8] = PadByte;
         blk[31:0] = {23'd0, n, 3'd0};
         q_in.block    = blk;
         q_in.too_long = ovf;
         full_in  = 1'b1;
         count_in = '0;
         ovf_in   = 1'b0;
         for (int i = 0; i < 16; i++) begin
            words_in[i] = '0;
         end
      end else begin
         count_in = n;
         ovf_in   = ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         full_ff  <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            words_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         full_ff  <= full_in;
         words_ff <= words_in;
      end
      q_ff <= q_in;
   end

endmodule

@@ rtl/sha1_back.sv @@
// Back part: 80 iterated SHA-1 rounds and five-word digest output (no rounds and a zero digest for a too-long message).
module sha1_back import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        msg_valid,
   output logic        msg_stall,
   input  msg_type     msg_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_too_long
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROUND = 3'b010,
      ST_OUT   = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic [511:0] w_ff, w_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [2:0]   idx_ff, idx_in;
   logic         tl_ff, tl_in;
   logic [159:0] dig;
   logic [31:0]  fv, kv, wt, wnew, t;

   assign msg_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign dig = tl_ff ? 160'd0 :
      {H0 + a_ff, H1 + b_ff, H2 + c_ff, H3 + d_ff, H4 + e_ff};
   assign rsp_digest_word = dig[32*(3'd4 - idx_ff) +: 32];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd4);
   assign rsp_too_long    = tl_ff;

   // 16-word sliding schedule: top word is w[t]
   assign wt   = w_ff[511:480];
   assign wnew = rotl1(w_ff[95:64] ^ w_ff[255:224] ^ w_ff[447:416] ^ w_ff[511:480]);

   always_comb begin
      if (rnd_ff < 7'd20) begin
         fv = (b_ff & c_ff) | (~b_ff & d_ff);
         kv = K0;
      end else if (rnd_ff < 7'd40) begin
         fv = b_ff ^ c_ff ^ d_ff;
         kv = K1;
      end else if (rnd_ff < 7'd60) begin
         fv = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         kv = K2;
      end else begin
         fv = b_ff ^ c_ff ^ d_ff;
         kv = K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + fv + e_ff + wt + kv;
   end

   always_comb begin
      state_in = state_ff;
      w_in = w_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      rnd_in = rnd_ff;
      idx_in = idx_ff;
      tl_in  = tl_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (msg_valid) begin
               w_in = msg_data.block;
               tl_in = msg_data.too_long;
               a_in = H0; b_in = H1; c_in = H2; d_in = H3; e_in = H4;
               rnd_in = '0;
               idx_in = '0;
               state_in = msg_data.too_long ? ST_OUT : ST_ROUND;
            end
         end
         ST_ROUND: begin
            w_in = {w_ff[479:0], wnew};
            e_in = d_ff;
            d_in = c_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            b_in = a_ff;
            a_in = t;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0; e_ff <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      end
      w_ff  <= w_in;
      tl_ff <= tl_in;
   end

endmodule

@@ rtl/sha1_single_block_hash_core.sv @@
// Top level of the single-block SHA-1 hash core.
// Flow: a message end registers its padded block in the front part; the back part takes it
//   when idle, runs 80 rounds in one shared round unit (none if too long), then 1 word/cycle unless rsp_stall.
// Throughput: one byte per cycle while collecting and req_stall is low; the round loop plus five
//   output words set the message rate; one finished block waits between parts.
// Reset: synchronous, active high; clears byte store, counters, state machine.
module sha1_single_block_hash_core import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_too_long
);

   // one-entry queue of padded blocks between the parts
   logic    msg_valid;
   logic    msg_stall;
   msg_type msg_data;

   sha1_front u_front (
      .clock, .reset,
      .req_valid, .req_stall, .req_data_byte, .req_has_byte, .req_end_of_message,
      .msg_valid, .msg_stall, .msg_data
   );

   sha1_back u_back (
      .clock, .reset,
      .msg_valid, .msg_stall, .msg_data,
      .rsp_valid, .rsp_stall, .rsp_digest_word, .rsp_word_index,
      .rsp_last_word, .rsp_too_long
   );

endmodule
